/* rtl/isps_pkg.sv */
// Shared types and constants of the isolated plus shape counter.
`timescale 1ns / 1ps
`default_nettype none

package isps_pkg;

    // Register map of the configuration port
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Result word
    localparam int COUNT_W = 10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    // Lanes carried by every cell of the line chain
    localparam int LANES     = 4;
    localparam int LANE_ROW1 = 0;   // pixel one row above
    localparam int LANE_ROW2 = 1;   // pixel two rows above
    localparam int LANE_ROW3 = 2;   // pixel three rows above
    localparam int LANE_CAND = 3;   // plus candidate still waiting on the row below

    // Position flags of the incoming pixel, handed to the window logic
    typedef struct packed {
        logic row_ge2;
        logic row_ge3;
        logic col_ge2;
        logic col_ge3;
        logic col_has_right;
        logic row_last;
    } isps_pos_t;

    // Window verdicts handed back to the top level
    typedef struct packed {
        logic cand;
        logic hit_now;
        logic hit_below;
    } isps_eval_t;

endpackage

`default_nettype wire

/* rtl/isps_cell.sv */
// One slot of the variable-length line chain, holding one column of every lane.
`timescale 1ns / 1ps
`default_nettype none

module isps_cell
    import isps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             shift,
    input  wire logic             is_tail,
    input  wire logic [LANES-1:0] ins,
    input  wire logic [LANES-1:0] nbr,
    output logic      [LANES-1:0] q
);

    logic [LANES-1:0] q_reg;
    logic [LANES-1:0] q_next;

    // the tail slot takes the new column, every other slot takes its neighbour
    assign q_next = is_tail ? ins : nbr;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* rtl/isps_plus_eval.sv */
// Column history and the plus shape test on the window around the incoming pixel.
`timescale 1ns / 1ps
`default_nettype none

module isps_plus_eval
    import isps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             shift,
    input  wire logic             pixel,
    input  wire logic [LANES-1:0] head,
    input  wire logic             row1_ahead,
    input  wire isps_pos_t        pos,
    output isps_eval_t            verdict
);

    // history of the current row and of the three rows above
    logic x1_reg, x2_reg;
    logic ah1_reg, ah2_reg, ah3_reg;
    logic bh1_reg, bh2_reg;
    logic ch1_reg;

    logic a0, b0, c0, cand_out;
    logic centre_ok;
    logic cand;

    assign a0       = head[LANE_ROW1];
    assign b0       = head[LANE_ROW2];
    assign c0       = head[LANE_ROW3];
    assign cand_out = head[LANE_CAND];

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            x1_reg  <= pixel;
            x2_reg  <= x1_reg;
            ah1_reg <= a0;
            ah2_reg <= ah1_reg;
            ah3_reg <= ah2_reg;
            bh1_reg <= b0;
            bh2_reg <= bh1_reg;
            ch1_reg <= c0;
        end
    end

    // centre sits one row up and one column left of the incoming pixel
    assign centre_ok = pos.row_ge2 & pos.col_ge2;

    always_comb
    begin
        cand = centre_ok
             & ah1_reg & a0 & ah2_reg & bh1_reg & x1_reg
             & ~bh2_reg & ~b0 & ~x2_reg & ~pixel
             & ~(pos.row_ge3 & ch1_reg)
             & ~(pos.col_ge3 & ah3_reg)
             & ~(pos.col_has_right & row1_ahead);

        verdict.cand      = cand;
        // no second row below the centre: the far cell lies outside, count now
        verdict.hit_now   = cand & pos.row_last;
        // candidate from one row back meets its far lower cell
        verdict.hit_below = pos.row_ge2 & cand_out & ~x1_reg;
    end

endmodule

`default_nettype wire

/* rtl/isolated_plus_shape_counter.sv */
// Top level of the isolated plus shape counter: counters, line chain and result register.
`timescale 1ns / 1ps
`default_nettype none

// Counts isolated plus shapes in a binary frame fed one pixel per word in raster
// order. A plus is an interior centre whose four axis neighbours are set, whose
// four diagonals are clear and whose four cells two steps out along the axes are
// clear or off the frame. The block takes one pixel every clock cycle, with no
// gap between rows or frames; the only pause comes from a result word that is
// held on a stalled output while the next result is already due. Frame size comes
// from image_width and image_height (0 acts as 1, values above the maximum act as
// the maximum); any write restarts the frame. Previous rows live in a chain of
// one-column cells, one per possible column, and each pixel is loaded into the
// cell at the current width so that it comes out of the head one row later. The
// test for a centre runs when the pixel diagonally below-right of it arrives; a
// passing centre is parked in its own lane of the chain until the pixel two rows
// below it arrives, or is counted at once on the second to last row. The result
// word (count saturating at 1023, and too_small when a side is under three,
// count then zero) appears on the cycle after the last pixel of the frame.
module isolated_plus_shape_counter
    import isps_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  pixel,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COUNT_W-1:0]         plus_count,
    output logic                       too_small
);

    // a 7-bit register cannot ask for more than 127 columns or rows
    localparam int CELLS = (MAX_WIDTH  < 127) ? MAX_WIDTH  : 127;
    localparam int ROWS  = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
    localparam int COL_W = $clog2(CELLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int RST_W = (CELLS < 64) ? CELLS : 64;
    localparam int RST_H = (ROWS  < 64) ? ROWS  : 64;

    // effective size minus one
    logic [CFG_DATA_W-1:0] wm1_reg, wm1_next;
    logic [CFG_DATA_W-1:0] hm1_reg, hm1_next;
    logic [CFG_DATA_W-1:0] eff_size;

    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]    plus_count_reg, plus_count_next;
    logic                  too_small_reg, too_small_next;

    logic                  accept;
    logic                  col_last;
    logic                  row_last;
    logic                  frame_small;
    logic [COUNT_W:0]      cnt_sum;
    logic [COUNT_W-1:0]    cnt_sat;

    logic [LANES-1:0]      line_q [CELLS];
    logic [LANES-1:0]      line_ins;

    isps_pos_t             pos;
    isps_eval_t            verdict;

    // hold only the last pixel of a frame while the previous result word is stalled
    assign in_stall = out_valid_reg & out_stall & col_last & row_last;
    assign accept   = in_valid & ~in_stall;

    assign col_last    = (CFG_DATA_W'(col_reg) == wm1_reg);
    assign row_last    = (CFG_DATA_W'(row_reg) == hm1_reg);
    assign frame_small = (wm1_reg < CFG_DATA_W'(2)) | (hm1_reg < CFG_DATA_W'(2));

    // clamp a written size into 1 .. maximum of the dimension addressed
    always_comb
    begin
        eff_size = cfg_data;
        if (cfg_data == '0)
        begin
            eff_size = CFG_DATA_W'(1);
        end
        else if (cfg_index == CFG_IMAGE_WIDTH && int'(cfg_data) > CELLS)
        begin
            eff_size = CFG_DATA_W'(CELLS);
        end
        else if (cfg_index == CFG_IMAGE_HEIGHT && int'(cfg_data) > ROWS)
        begin
            eff_size = CFG_DATA_W'(ROWS);
        end
    end

    // position flags of the incoming pixel
    always_comb
    begin
        pos.row_ge2       = (row_reg >= ROW_W'(2));
        pos.row_ge3       = (row_reg >= ROW_W'(3));
        pos.col_ge2       = (col_reg >= COL_W'(2));
        pos.col_ge3       = (col_reg >= COL_W'(3));
        pos.col_has_right = ~col_last;
        pos.row_last      = row_last;
    end

    // word pushed into the chain: each row lane feeds the next one down
    always_comb
    begin
        line_ins            = '0;
        line_ins[LANE_ROW1] = pixel;
        line_ins[LANE_ROW2] = line_q[0][LANE_ROW1];
        line_ins[LANE_ROW3] = line_q[0][LANE_ROW2];
        line_ins[LANE_CAND] = verdict.cand;
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_line
        logic [LANES-1:0] nbr;

        if (i == CELLS - 1)
        begin : g_end
            assign nbr = line_ins;
        end
        else
        begin : g_mid
            assign nbr = line_q[i+1];
        end

        isps_cell u_cell
        (
            .clk     (clk),
            .shift   (accept),
            .is_tail (wm1_reg == CFG_DATA_W'(i)),
            .ins     (line_ins),
            .nbr     (nbr),
            .q       (line_q[i])
        );
    end

    isps_plus_eval u_eval
    (
        .clk        (clk),
        .shift      (accept),
        .pixel      (pixel),
        .head       (line_q[0]),
        .row1_ahead (line_q[(CELLS > 1) ? 1 : 0][LANE_ROW1]),
        .pos        (pos),
        .verdict    (verdict)
    );

    // up to two shapes can complete on one pixel; saturate at the top
    assign cnt_sum = {1'b0, cnt_reg} + (COUNT_W+1)'(verdict.hit_now)
                   + (COUNT_W+1)'(verdict.hit_below);
    assign cnt_sat = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];

    always_comb
    begin
        wm1_next        = wm1_reg;
        hm1_next        = hm1_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg & out_stall;
        plus_count_next = plus_count_reg;
        too_small_next  = too_small_reg;

        if (cfg_we)
        begin
            // any write restarts the frame
            case (cfg_index)
                CFG_IMAGE_WIDTH:  wm1_next = eff_size - CFG_DATA_W'(1);
                CFG_IMAGE_HEIGHT: hm1_next = eff_size - CFG_DATA_W'(1);
                default:          ;
            endcase
            col_next = '0;
            row_next = '0;
            cnt_next = '0;
        end
        else if (accept)
        begin
            if (!col_last)
            begin
                col_next = col_reg + COL_W'(1);
                cnt_next = cnt_sat;
            end
            else if (!row_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
                cnt_next = cnt_sat;
            end
            else
            begin
                // last pixel of the frame: issue the result word
                col_next        = '0;
                row_next        = '0;
                cnt_next        = '0;
                out_valid_next  = 1'b1;
                plus_count_next = frame_small ? '0 : cnt_sat;
                too_small_next  = frame_small;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg       <= CFG_DATA_W'(RST_W - 1);
            hm1_reg       <= CFG_DATA_W'(RST_H - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wm1_reg       <= wm1_next;
            hm1_reg       <= hm1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plus_count_reg <= plus_count_next;
        too_small_reg  <= too_small_next;
    end

    assign out_valid  = out_valid_reg;
    assign plus_count = plus_count_reg;
    assign too_small  = too_small_reg;

endmodule

`default_nettype wire

/* test/tb_isolated_plus_shape_counter.sv */
// Testbench of the isolated plus shape counter: framed pixel streams checked against a predictor.
`timescale 1ns / 1ps

// Frames are streamed one pixel per word in raster order and every frame result word is
// compared with a prediction built from a private copy of the frame. The directed opening
// covers the size clamps (zero acting as one), the small-frame flag, a lone plus in the
// smallest frame that can hold one, and a register write restarting a part-sent frame.
// The random part then runs through many frame sizes: a few at the extremes (127 and 64)
// against a short side, and mostly small frames. Most frames carry planted plus shapes on
// a sparse background so that the isolation test is exercised; others are noise, some with
// planted shapes, or flat. Both handshake sides idle at random, apart from one calm stretch.
module tb_isolated_plus_shape_counter;
    import isps_pkg::*;

    localparam int MAX_SIDE = 64;
    // Around 1500 pixels in all; even with long sender gaps and output stalls the run
    // ends well inside this limit, so it leaves a wide margin.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_PIXELS = 1450;

    typedef struct packed {
        logic [COUNT_W-1:0] plus_total;
        logic               undersize;
    } frame_result_t;

    // Scoreboard: holds its own copy of the registers, the frame position and the
    // frame pixels, and predicts one result word per completed frame.
    class plus_scoreboard;
        bit [CFG_DATA_W-1:0] width_reg;
        bit [CFG_DATA_W-1:0] height_reg;
        int                  row;
        int                  col;
        bit                  frame_px [0:MAX_SIDE-1][0:MAX_SIDE-1];
        frame_result_t       awaited [$];
        int                  errors;
        int                  results_seen;

        function new();
            width_reg = 7'd64;
            height_reg = 7'd64;
            row = 0;
            col = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        static function int eff_size(bit [CFG_DATA_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return int'(v);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function bit px_at(int r, int c, int w, int h);
            if (r < 0 || c < 0 || r >= h || c >= w)
                return 1'b0;
            return frame_px[r][c];
        endfunction

        function int count_pluses(int w, int h);
            int r;
            int c;
            int total;
            total = 0;
            for (r = 1; r < h - 1; r++) begin
                for (c = 1; c < w - 1; c++) begin
                    if (px_at(r, c, w, h) && px_at(r - 1, c, w, h) && px_at(r + 1, c, w, h)
                        && px_at(r, c - 1, w, h) && px_at(r, c + 1, w, h)
                        && !px_at(r - 1, c - 1, w, h) && !px_at(r - 1, c + 1, w, h)
                        && !px_at(r + 1, c - 1, w, h) && !px_at(r + 1, c + 1, w, h)
                        && !px_at(r - 2, c, w, h) && !px_at(r + 2, c, w, h)
                        && !px_at(r, c - 2, w, h) && !px_at(r, c + 2, w, h)) begin
                        if (total < COUNT_MAX)
                            total++;
                    end
                end
            end
            return total;
        endfunction

        // Any write restarts the frame at its first pixel.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = val;
            else
                height_reg = val;
            row = 0;
            col = 0;
        endfunction

        function void note_pixel(bit v);
            int w;
            int h;
            frame_result_t res;
            w = eff_size(width_reg);
            h = eff_size(height_reg);
            if (row >= h || col >= w) begin
                row = 0;
                col = 0;
            end
            frame_px[row][col] = v;
            if (col + 1 < w) begin
                col++;
            end
            else if (row + 1 < h) begin
                row++;
                col = 0;
            end
            else begin
                res.undersize = (w < 3) || (h < 3);
                res.plus_total = res.undersize ? '0 : COUNT_W'(count_pluses(w, h));
                awaited.push_back(res);
                row = 0;
                col = 0;
            end
        endfunction

        task check_result(logic [COUNT_W-1:0] got_count, logic got_small);
            frame_result_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result word with none due (count %0d, small %0b)",
                                          got_count, got_small));
            end
            else begin
                want = awaited.pop_front();
                if (got_count !== want.plus_total)
                    report_mismatch($sformatf("plus_count %0d, predicted %0d",
                                              got_count, want.plus_total));
                if (got_small !== want.undersize)
                    report_mismatch($sformatf("too_small %0b, predicted %0b",
                                              got_small, want.undersize));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  pixel = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COUNT_W-1:0]    plus_count;
    logic                  too_small;

    plus_scoreboard sb;
    bit             calm = 1'b0;       // no idling on either side while set
    int             cycles = 0;
    bit             frame_img [0:MAX_SIDE-1][0:MAX_SIDE-1];

    isolated_plus_shape_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plus_count (plus_count),
        .too_small  (too_small)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up if the run hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stall at random about 13 percent of the time, never during the calm stretch.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    // Monitor: sample the handshakes just after the edge, before any update lands.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_pixel(pixel);
            if (out_valid && !out_stall)
                sb.check_result(plus_count, too_small);
        end
    end

    // Offer one pixel word, idling first at random; return at the edge that takes it.
    task send_pixel(bit v);
        if (!calm) begin
            while ($urandom_range(0, 99) < 13) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pixel <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold the sender until every predicted result word has arrived, then let the
    // block settle.
    task drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then drop the enable and idle so writes never overlap.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stream the first n pixels of the frame image in raster order.
    task send_frame(int w, int h, int n);
        int r;
        int c;
        int sent;
        sent = 0;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                if (sent < n) begin
                    send_pixel(frame_img[r][c]);
                    sent++;
                end
            end
        end
    endtask

    // Fill the frame image: mostly planted plus shapes on a sparse background, some
    // noise, some flat frames. Planting may spoil neighbouring pluses, which is wanted.
    task build_frame(int w, int h);
        int r;
        int c;
        int k;
        int style;
        int dens;
        int nplus;
        style = $urandom_range(0, 99);
        if (style < 70) begin
            k = $urandom_range(0, 2);
            dens = (k == 0) ? 0 : (k == 1) ? 8 : 20;
        end
        else if (style < 85)
            dens = 50;
        else if (style < 92)
            dens = $urandom_range(0, 1) ? 100 : 0;
        else
            dens = 60;
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                frame_img[r][c] = ($urandom_range(0, 99) < dens);
        if ((style < 70 || style >= 92) && w >= 3 && h >= 3) begin
            nplus = $urandom_range(1, 1 + (w * h) / 12);
            for (k = 0; k < nplus; k++) begin
                r = $urandom_range(1, h - 2);
                c = $urandom_range(1, w - 2);
                frame_img[r][c] = 1'b1;
                frame_img[r - 1][c] = 1'b1;
                frame_img[r + 1][c] = 1'b1;
                frame_img[r][c - 1] = 1'b1;
                frame_img[r][c + 1] = 1'b1;
                frame_img[r - 1][c - 1] = 1'b0;
                frame_img[r - 1][c + 1] = 1'b0;
                frame_img[r + 1][c - 1] = 1'b0;
                frame_img[r + 1][c + 1] = 1'b0;
                if (r >= 2)
                    frame_img[r - 2][c] = 1'b0;
                if (r + 2 < h)
                    frame_img[r + 2][c] = 1'b0;
                if (c >= 2)
                    frame_img[r][c - 2] = 1'b0;
                if (c + 2 < w)
                    frame_img[r][c + 2] = 1'b0;
            end
        end
    endtask

    // Pick a register value for one side: mostly small, sometimes below three.
    function bit [CFG_DATA_W-1:0] pick_side();
        int p;
        p = $urandom_range(0, 99);
        if (p < 88)
            return CFG_DATA_W'($urandom_range(3, 10));
        if (p < 94)
            return CFG_DATA_W'($urandom_range(0, 2));
        return CFG_DATA_W'($urandom_range(11, 20));
    endfunction

    initial
    begin
        bit [CFG_DATA_W-1:0] wv;
        bit [CFG_DATA_W-1:0] hv;
        int w;
        int h;
        int n;
        int nf;
        int phase;
        int random_px;

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both sizes zero act as a one-pixel frame: flagged as too small.
        write_reg(CFG_IMAGE_WIDTH, 7'd0);
        write_reg(CFG_IMAGE_HEIGHT, 7'd0);
        send_pixel(1'b1);
        drain_results();

        // Smallest frame that can hold a plus, with one plus in it.
        write_reg(CFG_IMAGE_WIDTH, 7'd3);
        write_reg(CFG_IMAGE_HEIGHT, 7'd3);
        frame_img[0][0] = 1'b0; frame_img[0][1] = 1'b1; frame_img[0][2] = 1'b0;
        frame_img[1][0] = 1'b1; frame_img[1][1] = 1'b1; frame_img[1][2] = 1'b1;
        frame_img[2][0] = 1'b0; frame_img[2][1] = 1'b1; frame_img[2][2] = 1'b0;
        send_frame(3, 3, 9);

        // Two pixels of a frame, then a write: drop what was sent and start the frame again.
        send_frame(3, 3, 2);
        drain_results();
        write_reg(CFG_IMAGE_HEIGHT, 7'd3);
        send_frame(3, 3, 9);
        drain_results();

        // Two rows only: too small despite a wide row.
        write_reg(CFG_IMAGE_WIDTH, 7'd5);
        write_reg(CFG_IMAGE_HEIGHT, 7'd2);
        for (n = 0; n < 5; n++) begin
            frame_img[0][n] = 1'b1;
            frame_img[1][n] = 1'b0;
        end
        send_frame(5, 2, 10);

        // Random phases: new sizes, an occasional broken frame, then whole frames.
        // The first three phases pin the size extremes against a short side.
        phase = 0;
        random_px = 0;
        while (random_px < RANDOM_PIXELS) begin
            case (phase)
                0: begin wv = 7'd127; hv = 7'd2;   end
                1: begin wv = 7'd3;   hv = 7'd127; end
                2: begin wv = 7'd64;  hv = 7'd3;   end
                default: begin wv = pick_side(); hv = pick_side(); end
            endcase
            calm = (phase >= 5 && phase < 9);
            drain_results();
            if (wv != sb.width_reg || $urandom_range(0, 3) == 0)
                write_reg(CFG_IMAGE_WIDTH, wv);
            if (hv != sb.height_reg || $urandom_range(0, 3) == 0)
                write_reg(CFG_IMAGE_HEIGHT, hv);
            w = plus_scoreboard::eff_size(wv);
            h = plus_scoreboard::eff_size(hv);

            if (phase >= 3 && w * h > 1 && $urandom_range(0, 5) == 0) begin
                build_frame(w, h);
                n = $urandom_range(1, w * h - 1);
                send_frame(w, h, n);
                random_px += n;
                drain_results();
                write_reg(CFG_IMAGE_HEIGHT, hv);
            end

            nf = (phase < 3) ? 1 : $urandom_range(1, 3);
            repeat (nf) begin
                build_frame(w, h);
                send_frame(w, h, w * h);
                random_px += w * h;
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
            phase++;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
